// File: rtl/sscnt_pkg.sv
// Shared types and constants of the stack signature count table.
package sscnt_pkg;

    localparam int FC_W = 7;

    localparam logic [1:0] K_FRAME = 2'd0;
    localparam logic [1:0] K_CLEAR = 2'd1;
    localparam logic [1:0] K_READ  = 2'd2;

    localparam logic [1:0] ST_NEW  = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_CLOSE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [63:0]      key;
        logic [FC_W-1:0]  frames;
        logic             bank;
        logic [5:0]       ridx;
        logic [3:0]       rslot;
    } t_cmd;

endpackage

// File: rtl/sscnt_ram.sv
// Generic single write port memory with one registered read port.
module sscnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/sscnt_front.sv
// Front end: accepts items, builds the chain key and buffers the chain's addresses.
module sscnt_front #(
    parameter int TRACE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_kind,
    input  logic [63:0]        i_frame_address,
    input  logic               i_last_frame,
    input  logic [5:0]         i_read_entry,
    input  logic [3:0]         i_read_frame,
    input  logic               i_q_full,
    output logic               o_q_push,
    output sscnt_pkg::t_cmd    o_q_cmd,
    input  logic               i_release,
    input  logic               i_release_bank,
    input  logic [((2 * TRACE_DEPTH > 1) ? $clog2(2 * TRACE_DEPTH) : 1)-1:0] i_pend_raddr,
    output logic [63:0]        o_pend_rdata
);
    import sscnt_pkg::*;

    localparam int OW  = $clog2(TRACE_DEPTH + 1);
    localparam int PD  = 2 * TRACE_DEPTH;
    localparam int PAW = (PD > 1) ? $clog2(PD) : 1;

    logic [63:0]   r_key;
    logic [OW-1:0] r_off;
    logic          r_bank;
    logic [1:0]    r_busy;

    logic          accept;
    logic [63:0]   n_key;
    logic [OW-1:0] n_off;
    logic [1:0]    n_busy;
    logic          close;
    logic          pend_we;
    logic [PAW-1:0] pend_waddr;

    assign o_full = i_q_full | r_busy[r_bank];
    assign accept = i_push & ~o_full;
    assign n_key  = r_key + i_frame_address;
    assign n_off  = r_off + OW'(1);

    assign pend_we    = accept && (i_kind == K_FRAME) && (i_frame_address != 64'd0);
    assign pend_waddr = r_bank ? (PAW'(TRACE_DEPTH) + PAW'(r_off)) : PAW'(r_off);

    sscnt_ram #(.WIDTH(64), .DEPTH(PD)) u_pend (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (i_frame_address),
        .i_raddr (i_pend_raddr),
        .o_rdata (o_pend_rdata)
    );

    always_comb begin
        close          = 1'b0;
        o_q_push       = 1'b0;
        o_q_cmd.op     = OP_CLOSE;
        o_q_cmd.key    = r_key;
        o_q_cmd.frames = FC_W'(r_off);
        o_q_cmd.bank   = r_bank;
        o_q_cmd.ridx   = i_read_entry;
        o_q_cmd.rslot  = i_read_frame;
        if (accept) begin
            unique case (i_kind)
                K_FRAME: begin
                    if (i_frame_address == 64'd0) begin
                        close = 1'b1;
                    end else if (i_last_frame || (n_off >= OW'(TRACE_DEPTH))) begin
                        close          = 1'b1;
                        o_q_cmd.key    = n_key;
                        o_q_cmd.frames = FC_W'(n_off);
                    end
                    o_q_push = close;
                end
                K_CLEAR: begin
                    o_q_push   = 1'b1;
                    o_q_cmd.op = OP_CLEAR;
                end
                K_READ: begin
                    o_q_push   = 1'b1;
                    o_q_cmd.op = OP_READ;
                end
                default: begin
                    o_q_push = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_release) begin
            n_busy[i_release_bank] = 1'b0;
        end
        if (close) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_off  <= '0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
            if (close) begin
                r_key  <= '0;
                r_off  <= '0;
                r_bank <= ~r_bank;
            end else if (pend_we) begin
                r_key <= n_key;
                r_off <= n_off;
            end
        end
    end
endmodule

// File: rtl/sscnt_queue.sv
// Two-entry command queue between the front end and the table engine.
module sscnt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sscnt_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output sscnt_pkg::t_cmd o_cmd
);
    import sscnt_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// File: rtl/sscnt_back.sv
// Table engine: linear key search, count update, chain append, clear and read.
module sscnt_back #(
    parameter int TABLE_ENTRIES = 64,
    parameter int TRACE_DEPTH   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  sscnt_pkg::t_cmd i_q_cmd,
    output logic            o_q_pop,
    output logic            o_release,
    output logic            o_release_bank,
    output logic [((2 * TRACE_DEPTH > 1) ? $clog2(2 * TRACE_DEPTH) : 1)-1:0] o_pend_raddr,
    input  logic [63:0]     i_pend_rdata,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [1:0]      o_status,
    output logic [5:0]      o_entry_index,
    output logic [63:0]     o_chain_key,
    output logic [31:0]     o_hit_count,
    output logic [4:0]      o_frame_count,
    output logic [63:0]     o_address_word,
    output logic [6:0]      o_entries_used
);
    import sscnt_pkg::*;

    localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW  = $clog2(TABLE_ENTRIES + 1);
    localparam int AD  = TABLE_ENTRIES * TRACE_DEPTH;
    localparam int AW  = (AD > 1) ? $clog2(AD) : 1;
    localparam int PAW = (2 * TRACE_DEPTH > 1) ? $clog2(2 * TRACE_DEPTH) : 1;
    localparam int MW  = 64 + 32 + FC_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_COPY   = 4'b0100,
        S_READ   = 4'b1000
    } t_state;

    t_state          r_state;
    t_cmd            r_cmd;
    logic [UW-1:0]   r_used;
    logic [UW-1:0]   r_idx;
    logic            r_cmp;
    logic [EW-1:0]   r_cidx;
    logic [FC_W-1:0] r_cnt;
    logic            r_cpv;
    logic [FC_W-1:0] r_wslot;
    logic            r_out_valid;
    logic [1:0]      r_status;
    logic [5:0]      r_index;
    logic [63:0]     r_key;
    logic [31:0]     r_count;
    logic [4:0]      r_frames;
    logic [63:0]     r_word;

    logic            take;
    logic            hit;
    logic            miss;
    logic            rd_out;
    logic            m_we;
    logic [EW-1:0]   m_waddr;
    logic [MW-1:0]   m_wdata;
    logic [EW-1:0]   m_raddr;
    logic [MW-1:0]   m_rdata;
    logic [63:0]     m_key;
    logic [31:0]     m_count;
    logic [FC_W-1:0] m_fc;
    logic [31:0]     sat_count;
    logic            a_we;
    logic [AW-1:0]   a_waddr;
    logic [AW-1:0]   a_raddr;
    logic [63:0]     a_rdata;
    logic            copy_done;

    assign m_key   = m_rdata[MW-1 -: 64];
    assign m_count = m_rdata[FC_W +: 32];
    assign m_fc    = m_rdata[FC_W-1:0];
    assign sat_count = (m_count == COUNT_MAX) ? m_count : m_count + 32'd1;

    assign take    = (r_state == S_IDLE) && !r_out_valid && !i_q_empty;
    assign o_q_pop = take;
    assign rd_out  = ({5'd0, i_q_cmd.ridx} >= 11'(r_used))
                  || ({5'd0, i_q_cmd.ridx} >= 11'(TABLE_ENTRIES));

    assign hit  = (r_state == S_SEARCH) && r_cmp && (m_key == r_cmd.key);
    assign miss = (r_state == S_SEARCH) && !hit && (r_idx >= r_used);

    assign m_we    = hit | miss;
    assign m_waddr = hit ? r_cidx : EW'(r_used);
    assign m_wdata = hit ? {m_key, sat_count, m_fc} : {r_cmd.key, 32'd1, r_cmd.frames};
    assign m_raddr = (r_state == S_SEARCH) ? EW'(r_idx) : EW'(i_q_cmd.ridx);

    assign o_pend_raddr = r_cmd.bank ? (PAW'(TRACE_DEPTH) + PAW'(r_cnt)) : PAW'(r_cnt);

    assign a_we    = (r_state == S_COPY) && r_cpv;
    assign a_waddr = AW'(r_used) * AW'(TRACE_DEPTH) + AW'(r_wslot);
    assign a_raddr = AW'(i_q_cmd.ridx) * AW'(TRACE_DEPTH) + AW'(i_q_cmd.rslot);
    assign copy_done = (r_state == S_COPY) && (r_cnt >= r_cmd.frames) && !r_cpv;

    sscnt_ram #(.WIDTH(MW), .DEPTH(TABLE_ENTRIES)) u_meta (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    sscnt_ram #(.WIDTH(64), .DEPTH(AD)) u_addr (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (i_pend_rdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    assign o_release = (take && (i_q_cmd.op == OP_CLOSE) && (r_used >= UW'(TABLE_ENTRIES)))
                    || hit || copy_done;
    assign o_release_bank = take ? i_q_cmd.bank : r_cmd.bank;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_q_cmd;
        end
        if (take) begin
            r_index  <= (i_q_cmd.op == OP_CLOSE) ? 6'd0 : i_q_cmd.ridx;
            r_status <= (i_q_cmd.op == OP_CLOSE) ? ST_FULL : ST_READ;
            r_key    <= (i_q_cmd.op == OP_CLOSE) ? i_q_cmd.key : 64'd0;
            r_count  <= '0;
            r_frames <= (i_q_cmd.op == OP_CLOSE) ? 5'(i_q_cmd.frames) : 5'd0;
            r_word   <= '0;
        end else if (hit) begin
            r_status <= ST_HIT;
            r_index  <= 6'(r_cidx);
            r_key    <= r_cmd.key;
            r_count  <= sat_count;
            r_frames <= 5'(m_fc);
        end else if (copy_done) begin
            r_status <= ST_NEW;
            r_index  <= 6'(r_used);
            r_key    <= r_cmd.key;
            r_count  <= 32'd1;
            r_frames <= 5'(r_cmd.frames);
        end else if (r_state == S_READ) begin
            r_key    <= m_key;
            r_count  <= m_count;
            r_frames <= 5'(m_fc);
            r_word   <= ((FC_W'(r_cmd.rslot) < m_fc) && (FC_W'(r_cmd.rslot) < FC_W'(TRACE_DEPTH)))
                        ? a_rdata : 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_cmp       <= 1'b0;
            r_cidx      <= '0;
            r_cnt       <= '0;
            r_cpv       <= 1'b0;
            r_wslot     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        unique case (i_q_cmd.op)
                            OP_CLOSE: begin
                                if (r_used >= UW'(TABLE_ENTRIES)) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_idx   <= '0;
                                    r_cmp   <= 1'b0;
                                    r_state <= S_SEARCH;
                                end
                            end
                            OP_CLEAR: begin
                                r_used <= '0;
                            end
                            OP_READ: begin
                                if (rd_out) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (miss) begin
                        r_cnt   <= '0;
                        r_cpv   <= 1'b0;
                        r_state <= S_COPY;
                    end else begin
                        r_cmp  <= 1'b1;
                        r_cidx <= EW'(r_idx);
                        r_idx  <= r_idx + UW'(1);
                    end
                end
                S_COPY: begin
                    if (copy_done) begin
                        r_used      <= r_used + UW'(1);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (r_cnt < r_cmd.frames) begin
                        r_cpv   <= 1'b1;
                        r_wslot <= r_cnt;
                        r_cnt   <= r_cnt + FC_W'(1);
                    end else begin
                        r_cpv <= 1'b0;
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty        = ~r_out_valid;
    assign o_status       = r_status;
    assign o_entry_index  = r_index;
    assign o_chain_key    = r_key;
    assign o_hit_count    = r_count;
    assign o_frame_count  = r_frames;
    assign o_address_word = r_word;
    assign o_entries_used = 7'(r_used);

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_ENTRIES))
        else $error("Entry count exceeds the table size.");
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_idx <= r_used))
        else $error("Search index ran past the used entries.");
    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_cnt <= r_cmd.frames))
        else $error("Copy ran past the chain length.");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> r_out_valid && $stable(r_key))
        else $error("Waiting result was overwritten.");
`endif
endmodule

// File: rtl/stack_signature_count_table.sv
// Top level of the stack signature count table.
//  channel  | handshake         | payload
//  input    | i_push / o_full   | i_kind, i_frame_address, i_last_frame, i_read_entry, i_read_frame
//  result   | o_empty / i_pop   | o_status, o_entry_index, o_chain_key, o_hit_count,
//           |                   | o_frame_count, o_address_word, o_entries_used
// A frame that does not close its chain only updates the front end and does not reach the queue.
// A chain close searches the used entries at one entry per cycle through the
// entry memory read port, then a new chain copies its frames at one per cycle.
// A read in range passes through the S_READ state of the table engine; a clear is handled in S_IDLE.
// Input stalls while the command queue is full or both chain buffers wait on the table engine.
// Reset is synchronous; the table memories need no clearing pass.
module stack_signature_count_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int TRACE_DEPTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_frame_address,
    input  logic        i_last_frame,
    input  logic [5:0]  i_read_entry,
    input  logic [3:0]  i_read_frame,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_status,
    output logic [5:0]  o_entry_index,
    output logic [63:0] o_chain_key,
    output logic [31:0] o_hit_count,
    output logic [4:0]  o_frame_count,
    output logic [63:0] o_address_word,
    output logic [6:0]  o_entries_used
);
    import sscnt_pkg::*;

    localparam int PAW = (2 * TRACE_DEPTH > 1) ? $clog2(2 * TRACE_DEPTH) : 1;

    logic           q_full;
    logic           q_push;
    t_cmd           q_in;
    logic           q_pop;
    logic           q_empty;
    t_cmd           q_out;
    logic           release_bank;
    logic           release_which;
    logic [PAW-1:0] pend_raddr;
    logic [63:0]    pend_rdata;

    sscnt_front #(.TRACE_DEPTH(TRACE_DEPTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_kind          (i_kind),
        .i_frame_address (i_frame_address),
        .i_last_frame    (i_last_frame),
        .i_read_entry    (i_read_entry),
        .i_read_frame    (i_read_frame),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_cmd         (q_in),
        .i_release       (release_bank),
        .i_release_bank  (release_which),
        .i_pend_raddr    (pend_raddr),
        .o_pend_rdata    (pend_rdata)
    );

    sscnt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    sscnt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .TRACE_DEPTH(TRACE_DEPTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_cmd        (q_out),
        .o_q_pop        (q_pop),
        .o_release      (release_bank),
        .o_release_bank (release_which),
        .o_pend_raddr   (pend_raddr),
        .i_pend_rdata   (pend_rdata),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_status       (o_status),
        .o_entry_index  (o_entry_index),
        .o_chain_key    (o_chain_key),
        .o_hit_count    (o_hit_count),
        .o_frame_count  (o_frame_count),
        .o_address_word (o_address_word),
        .o_entries_used (o_entries_used)
    );
endmodule
